// File: src/indexed_list_store_assert.svh
// assertion macros shared by the indexed list store rtl
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define ILS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ils_pkg.sv
// types, constants and command codes of the indexed list store
`timescale 1ns / 1ps

package ils_pkg;

    localparam int CAPACITY = 16;
    localparam int WORD_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [3:0] CMD_APPEND       = 4'd0;
    localparam logic [3:0] CMD_INSERT_AT    = 4'd1;
    localparam logic [3:0] CMD_REMOVE_VALUE = 4'd2;
    localparam logic [3:0] CMD_REMOVE_AT    = 4'd3;
    localparam logic [3:0] CMD_GET          = 4'd4;
    localparam logic [3:0] CMD_SET          = 4'd5;
    localparam logic [3:0] CMD_FIRST_INDEX  = 4'd6;
    localparam logic [3:0] CMD_LAST_INDEX   = 4'd7;
    localparam logic [3:0] CMD_CLEAR        = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_WRITE = 2'd1;
    localparam logic [1:0] CELL_OPEN  = 2'd2;
    localparam logic [1:0] CELL_CLOSE = 2'd3;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [4:0]  position;
        logic [31:0] item_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [3:0]  index_out;
        logic        found;
        logic [1:0]  status;
        logic [4:0]  count_out;
    } out_item_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [IDX_W-1:0]  target;
        logic [WORD_W-1:0] wr_value;
        logic              cmp_en;
        logic [WORD_W-1:0] cmp_value;
    } cell_ctrl_t;

endpackage

// File: src/ils_cell.sv
// one list entry cell: holds a word, compares it and moves it along the chain
`timescale 1ns / 1ps

module ils_cell (
    input  logic                       aclk,
    input  ils_pkg::cell_ctrl_t        ctrl,
    input  logic [ils_pkg::IDX_W-1:0]  cell_idx,
    input  logic [ils_pkg::WORD_W-1:0] left_word,
    input  logic [ils_pkg::WORD_W-1:0] right_word,
    output logic [ils_pkg::WORD_W-1:0] entry_word,
    output logic                       match
);
    import ils_pkg::*;

    logic [WORD_W-1:0] entry_reg;
    logic [WORD_W-1:0] entry_next;
    logic              match_reg;
    logic              match_next;

    always_comb begin
        entry_next = entry_reg;
        case (ctrl.mode)
            CELL_WRITE: begin
                if (cell_idx == ctrl.target) begin
                    entry_next = ctrl.wr_value;
                end
            end
            CELL_OPEN: begin
                if (cell_idx == ctrl.target) begin
                    entry_next = ctrl.wr_value;
                end else if (cell_idx > ctrl.target) begin
                    entry_next = left_word;
                end
            end
            CELL_CLOSE: begin
                if (cell_idx >= ctrl.target) begin
                    entry_next = right_word;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    assign match_next = ctrl.cmp_en ? (entry_reg == ctrl.cmp_value) : match_reg;

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry_word = entry_reg;
    assign match      = match_reg;

endmodule

// File: src/indexed_list_store.sv
// indexed list store top level: command decode, count and a chain of entry cells
//
//  channel | ports                  | moves
//  --------+------------------------+------------------------------------------
//  input   | s_valid s_ready s_item | one command request (cmd, position, value)
//  result  | m_valid m_ready m_item | one result per request, in request order
//
// each request is handled at its accept edge, which latches the compare of every
// cell against the value, and then at an execute edge, which decodes the match
// vector, moves the cells and loads the result register. s_ready stays low while
// a request is pending, so a new request is taken only after the last one executed.
// reset clears the count and handshake state; the entry words need no clearing.
// a stalled result holds the update back until the result register frees.
`timescale 1ns / 1ps

module indexed_list_store (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ils_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ils_pkg::out_item_t m_item
);
    import ils_pkg::*;

`include "indexed_list_store_assert.svh"

    function automatic logic [IDX_W-1:0] onehot_index(input logic [CAPACITY-1:0] oh);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (oh[i]) begin
                r = r | IDX_W'(i);
            end
        end
        return r;
    endfunction

    logic              pend_reg;
    logic              pend_next;
    in_item_t          req_reg;
    in_item_t          req_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    out_item_t         m_item_reg;
    out_item_t         m_item_next;

    logic              s_fire;
    logic              exec_fire;
    cell_ctrl_t        ctrl;
    logic [1:0]        mode_sel;
    logic [IDX_W-1:0]  target_sel;
    logic [WORD_W-1:0] entry_words [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] valid_mask;
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] hit_rev;
    logic [CAPACITY-1:0] first_oh;
    logic [CAPACITY-1:0] last_oh_rev;
    logic [IDX_W-1:0]  first_idx;
    logic [IDX_W-1:0]  last_idx;
    logic              any_hit;
    logic [IDX_W-1:0]  read_sel;
    logic [WORD_W-1:0] read_word;
    logic              pos_in;
    logic              pos_le;
    logic              is_full;
    out_item_t         result;

    assign s_ready   = !pend_reg;
    assign s_fire    = s_valid && s_ready;
    assign exec_fire = pend_reg && (!m_valid_reg || m_ready);

    // cell chain
    assign ctrl.mode      = exec_fire ? mode_sel : CELL_HOLD;
    assign ctrl.target    = target_sel;
    assign ctrl.wr_value  = req_reg.item_value[WORD_W-1:0];
    assign ctrl.cmp_en    = s_fire;
    assign ctrl.cmp_value = s_item.item_value[WORD_W-1:0];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = entry_words[g];
        end else begin : g_mid_l
            assign left_w = entry_words[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_w = entry_words[g];
        end else begin : g_mid_r
            assign right_w = entry_words[g+1];
        end
        ils_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_idx   (IDX_W'(g)),
            .left_word  (left_w),
            .right_word (right_w),
            .entry_word (entry_words[g]),
            .match      (match_vec[g])
        );
    end

    // match decode over live entries
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            valid_mask[i] = CNT_W'(i) < count_reg;
        end
    end

    assign hit_vec = match_vec & valid_mask;
    assign any_hit = |hit_vec;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            hit_rev[i] = hit_vec[CAPACITY-1-i];
        end
    end

    assign first_oh    = hit_vec & (~hit_vec + CAPACITY'(1));
    assign last_oh_rev = hit_rev & (~hit_rev + CAPACITY'(1));
    assign first_idx   = onehot_index(first_oh);
    assign last_idx    = IDX_W'(CAPACITY - 1) - onehot_index(last_oh_rev);

    assign pos_in  = req_reg.position < count_reg;
    assign pos_le  = req_reg.position <= count_reg;
    assign is_full = count_reg == CNT_W'(CAPACITY);

    assign read_sel  = (req_reg.cmd == CMD_REMOVE_VALUE) ? first_idx
                                                         : req_reg.position[IDX_W-1:0];
    assign read_word = entry_words[read_sel];

    // command decode
    always_comb begin
        mode_sel         = CELL_HOLD;
        target_sel       = req_reg.position[IDX_W-1:0];
        count_next       = count_reg;
        result.data_out  = '0;
        result.index_out = '0;
        result.found     = 1'b0;
        result.status    = ST_OK;
        unique case (req_reg.cmd)
            CMD_APPEND: begin
                if (is_full) begin
                    result.status = ST_FULL;
                end else begin
                    mode_sel   = CELL_WRITE;
                    target_sel = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_INSERT_AT: begin
                if (!pos_le) begin
                    result.status = ST_RANGE;
                end else if (is_full) begin
                    result.status = ST_FULL;
                end else begin
                    mode_sel   = CELL_OPEN;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE_VALUE: begin
                if (any_hit) begin
                    result.found    = 1'b1;
                    result.data_out = 32'(read_word);
                    mode_sel        = CELL_CLOSE;
                    target_sel      = first_idx;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            CMD_REMOVE_AT: begin
                if (!pos_in) begin
                    result.status = ST_RANGE;
                end else begin
                    result.data_out = 32'(read_word);
                    mode_sel        = CELL_CLOSE;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            CMD_GET: begin
                if (!pos_in) begin
                    result.status = ST_RANGE;
                end else begin
                    result.data_out = 32'(read_word);
                end
            end
            CMD_SET: begin
                if (!pos_in) begin
                    result.status = ST_RANGE;
                end else begin
                    result.data_out = 32'(read_word);
                    mode_sel        = CELL_WRITE;
                end
            end
            CMD_FIRST_INDEX: begin
                if (any_hit) begin
                    result.found     = 1'b1;
                    result.index_out = 4'(first_idx);
                end
            end
            CMD_LAST_INDEX: begin
                if (any_hit) begin
                    result.found     = 1'b1;
                    result.index_out = 4'(last_idx);
                end
            end
            CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
        result.count_out = 5'(count_next);
    end

    // handshake and result register
    always_comb begin
        pend_next    = pend_reg;
        req_next     = req_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (exec_fire) begin
            pend_next    = 1'b0;
            m_valid_next = 1'b1;
            m_item_next  = result;
        end
        if (s_fire) begin
            pend_next = 1'b1;
            req_next  = s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            count_reg   <= exec_fire ? count_next : count_reg;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `ILS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `ILS_ASSERT_NEXT(a_exec_result, exec_fire, m_valid && (m_item.count_out == 5'(count_reg)), "result count differs from list count")
    `ILS_ASSERT_NEXT(a_full_holds, exec_fire && (result.status == ST_FULL), $stable(count_reg), "full command changed count")
    `ILS_ASSERT_NEXT(a_remove_hit, exec_fire && (req_reg.cmd == CMD_REMOVE_VALUE) && any_hit, count_reg == $past(count_reg) - CNT_W'(1), "remove by value did not shrink list")

endmodule
